>>> rtl/rmdr_pkg.sv
// Package for the running mean / deviation / reliability block.
// Shared types, constants and the back-end state enum. No dependencies.
package rmdr_pkg;
  localparam int SAMPLE_BITS = 32;
  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS = 32;
  localparam int CFG_W = 64;
  localparam int REL_W = 23;
  localparam int RSUM_W = 48;

  localparam logic [1:0] REG_START_SUM = 2'd0;
  localparam logic [1:0] REG_START_DEV = 2'd1;
  localparam logic [1:0] REG_START_REL = 2'd2;
  localparam logic [1:0] REG_START_CNT = 2'd3;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [63:0] HUNDRED_FX = 64'd100 << FRACTION_BITS;

  typedef struct packed {
    logic action;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0] mean_deviation;
    logic [REL_W-1:0] reliability;
    logic [31:0] samples_seen;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_OLD, ST_DIV_NEW, ST_DEV, ST_DIV_DEV, ST_SHIFT,
    ST_DIV_REL, ST_REL, ST_DIV_RAVG, ST_DONE
  } st_t;
endpackage

>>> rtl/rmdr_divider.sv
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
// Uses rmdr_pkg.
module rmdr_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import rmdr_pkg::*;
  logic [63:0] rem, dsr;
  logic [6:0] cnt;
  logic busy;
  logic [64:0] trial;

  assign trial = {rem, quotient[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        rem <= '0;
        quotient <= dividend;
        dsr <= divisor;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
`endif
endmodule

>>> rtl/rmdr_front.sv
// Front end: accepts items into a two-entry queue towards the back end.
// Uses rmdr_pkg.
module rmdr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rmdr_pkg::cmd_t      cmd_in,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output rmdr_pkg::cmd_t      cmd_out
);
  import rmdr_pkg::*;
  cmd_t q [2];
  logic rd, wr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign cmd_valid = fill != 2'd0;
  assign cmd_out = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      rd <= 1'b0;
      wr <= 1'b0;
    end else begin
      if (push && !full) begin
        q[wr] <= cmd_in;
        wr <= ~wr;
      end
      if (cmd_take && cmd_valid) rd <= ~rd;
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((cmd_take && cmd_valid) ? 1 : 0);
    end
  end

`ifndef NO_ASSERTIONS
  a_take_valid: assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("take from empty queue");
  a_fill: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue overfilled");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> rd == wr)
    else $error("pointer mismatch");
`endif
endmodule

>>> rtl/rmdr_back.sv
// Back end: statistics state, sequencer and the shared divider; one result register.
// Uses rmdr_pkg and rmdr_divider.
module rmdr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  rmdr_pkg::cmd_t      cmd,
  input  logic signed [63:0]  start_sum,
  input  logic [62:0]         start_dev,
  input  logic [47:0]         start_rel,
  input  logic [31:0]         start_cnt,
  output logic                empty,
  input  logic                pop,
  output rmdr_pkg::res_t      res
);
  import rmdr_pkg::*;
  st_t st, st_next;
  logic signed [63:0] run_sum, new_sum, prev_mean, new_mean;
  logic [63:0] dev_sum, shift_full;
  logic [47:0] rel_sum;
  logic [COUNT_BITS-1:0] total;
  logic signed [31:0] mean_v;
  logic [31:0] dev_v, shift32;
  logic [REL_W-1:0] rel_v;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [63:0] prod;
  logic div_start, div_done;
  logic [63:0] dvd, dvs, quo, sq;
  logic neg;
  logic res_full;
  logic signed [63:0] smp64, cmd64, sum_add;
  logic ovf;
  logic ds2;
  logic [63:0] dvd2, dvs2;
  logic rel_go;
  logic [63:0] dvd_m, dvs_m;
  logic ds_m;

  function automatic logic [63:0] sat_u(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] absd(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [63:0] sat_rel(input logic [47:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {17'd0, a} + {1'b0, b};
    return (s > 65'h0ffffffffffff) ? 64'h0000ffffffffffff : s[63:0];
  endfunction

  rmdr_divider u_div (.clk, .rst, .start(ds_m), .dividend(dvd_m),
    .divisor(dvs_m), .done(div_done), .quotient(quo));

  // signed view: magnitude divide then fix sign
  assign sq = neg ? (~quo + 64'd1) : quo;
  assign empty = !res_full;

  assign smp64 = 64'(smp);
  assign cmd64 = 64'($signed(cmd.sample));
  assign sum_add = run_sum + cmd64;
  assign ovf = (run_sum[63] == cmd64[63]) && (sum_add[63] != run_sum[63]);

  always_comb begin
    st_next = st;
    cmd_take = 1'b0;
    div_start = 1'b0;
    dvd = '0;
    dvs = '0;
    unique case (st)
      ST_IDLE: if (cmd_valid && !res_full) st_next = ST_DONE;
      ST_DIV_OLD: if (div_done) st_next = ST_DIV_NEW;
      ST_DIV_NEW: if (div_done) st_next = ST_DEV;
      ST_DEV: st_next = ST_DIV_DEV;
      ST_DIV_DEV: if (div_done) st_next = ST_SHIFT;
      ST_SHIFT: st_next = ST_DIV_REL;
      ST_DIV_REL: if (div_done) st_next = ST_REL;
      ST_REL: st_next = ST_DIV_RAVG;
      ST_DIV_RAVG: if (div_done) st_next = ST_IDLE;
      ST_DONE: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
    if (st == ST_IDLE && cmd_valid && !res_full) begin
      cmd_take = 1'b1;
      if (cmd.action == ACT_ADD && total != '0) begin
        st_next = ST_DIV_OLD;
        div_start = 1'b1;
        dvd = mag(run_sum);
        dvs = 64'(total);
      end
    end
  end

  // divider start for the later divisions, except the relative shift division
  always_comb begin
    ds2 = 1'b0;
    dvd2 = '0;
    dvs2 = 64'(total);
    if (st == ST_DIV_OLD && div_done) begin
      ds2 = 1'b1; dvd2 = mag(new_sum); dvs2 = 64'(total) + 64'd1;
    end else if (st == ST_DEV) begin
      ds2 = 1'b1; dvd2 = sat_u(dev_sum, absd(new_mean, smp64));
    end else if (st == ST_REL) begin
      ds2 = 1'b1; dvd2 = {16'd0, rel_sum};
    end
  end

  // relative shift division starts on a flag registered from ST_SHIFT, when the product register holds the product
  always_ff @(posedge clk) begin
    if (rst) rel_go <= 1'b0;
    else rel_go <= (st == ST_SHIFT);
  end

  always_comb begin
    ds_m = div_start | ds2 | rel_go;
    dvd_m = div_start ? dvd : (rel_go ? prod : dvd2);
    dvs_m = div_start ? dvs : (rel_go ? ((dev_v == '0) ? 64'd1 : 64'(dev_v)) : dvs2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      res_full <= 1'b0;
      run_sum <= '0;
      dev_sum <= '0;
      rel_sum <= '0;
      total <= '0;
      mean_v <= '0;
      dev_v <= '0;
      rel_v <= '0;
    end else begin
      st <= st_next;
      if (pop && res_full) res_full <= 1'b0;
      unique case (st)
        ST_IDLE: if (cmd_take) begin
          smp <= cmd.sample;
          neg <= run_sum[63];
          new_sum <= ovf ? (run_sum[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_add;
          if (cmd.action == ACT_RESTART) begin
            run_sum <= start_sum;
            dev_sum <= {1'b0, start_dev};
            rel_sum <= start_rel;
            total <= start_cnt;
            mean_v <= '0;
            dev_v <= '0;
            rel_v <= '0;
          end else if (total == '0) begin
            run_sum <= ovf ? (run_sum[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_add;
            total <= total + 1'b1;
          end
        end
        ST_DIV_OLD: if (div_done) begin
          prev_mean <= sq;
          neg <= new_sum[63];
        end
        ST_DIV_NEW: if (div_done) new_mean <= sq;
        default: ;
      endcase
      if (st == ST_DEV) begin
        if (new_mean > 64'sd2147483647) mean_v <= 32'sh7fffffff;
        else if (new_mean < -64'sd2147483648) mean_v <= 32'sh80000000;
        else mean_v <= new_mean[31:0];
        dev_sum <= sat_u(dev_sum, absd(new_mean, smp64));
        shift_full <= absd(prev_mean, new_mean);
        neg <= 1'b0;
      end
      if (st == ST_DIV_DEV && div_done) begin
        dev_v <= (quo[63:32] != '0) ? '1 : quo[31:0];
        shift32 <= (shift_full[63:32] != '0) ? '1 : shift_full[31:0];
      end
      if (st == ST_SHIFT) prod <= 64'(shift32) * HUNDRED_FX;
      if (st == ST_DIV_REL && div_done) begin
        if (dev_v == '0) rel_sum <= 48'(sat_rel(rel_sum, HUNDRED_FX));
        else if (shift32 < dev_v) rel_sum <= 48'(sat_rel(rel_sum, HUNDRED_FX - quo));
      end
      if (st == ST_DIV_RAVG && div_done) begin
        rel_v <= (quo[63:REL_W] != '0) ? '1 : quo[REL_W-1:0];
        run_sum <= new_sum;
        if (total != '1) total <= total + 1'b1;
      end
      if ((st == ST_DIV_RAVG && div_done) || st == ST_DONE) res_full <= 1'b1;
    end
  end

  assign res.mean = mean_v;
  assign res.mean_deviation = dev_v;
  assign res.reliability = rel_v;
  assign res.samples_seen = total;

`ifndef NO_ASSERTIONS
  a_take_room: assert property (@(posedge clk) disable iff (rst) cmd_take |-> !res_full)
    else $error("item taken with result pending");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_full && !pop) |=> res_full)
    else $error("result dropped without pop");
  a_idle_take: assert property (@(posedge clk) disable iff (rst) cmd_take |-> st == ST_IDLE)
    else $error("sequencer slip");
`endif
endmodule

>>> rtl/running_mean_deviation_reliability_top.sv
// Top level: config registers, front queue and back-end sequencer.
// Uses rmdr_pkg, rmdr_front, rmdr_back.
// Usage:
//   Input queue: drive action/sample with push while full is low.
//   Action restart reloads from start_* registers; clears mean, deviation, reliability.
//   Result register: while empty is low, mean, mean_deviation, reliability and
//   samples_seen hold the result; pop takes it.
//   Config: cfg_we, cfg_index, cfg_data write one start register per cycle;
//   write only while the block is idle.
// Sequence: a restart or first sample goes from ST_IDLE through ST_DONE to the
//   result register; any other add runs five 64-step passes of one serial
//   divider plus the sequencing steps between them.
// Flow: one item at a time; the back end takes the next item the cycle
//   after the previous result is popped. A two-entry queue buffers input.
// Reset (rst, synchronous) clears the running sums, count, outputs, start registers, state and queue pointers.
// When pop stays low the one result register holds, the back end waits and
// the input queue fills, then full rises.
module running_mean_deviation_reliability_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic signed [31:0] sample,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] mean,
  output logic [31:0] mean_deviation,
  output logic [22:0] reliability,
  output logic [31:0] samples_seen,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rmdr_pkg::*;
  logic signed [63:0] start_sum;
  logic [62:0] start_dev;
  logic [47:0] start_rel;
  logic [31:0] start_cnt;
  cmd_t cin, cq;
  res_t r;
  logic cv, ct;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_sum <= '0;
      start_dev <= '0;
      start_rel <= '0;
      start_cnt <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_SUM: start_sum <= cfg_data;
        REG_START_DEV: start_dev <= cfg_data[62:0];
        REG_START_REL: start_rel <= cfg_data[47:0];
        REG_START_CNT: start_cnt <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cin.action = action;
  assign cin.sample = sample;

  rmdr_front u_front (.clk, .rst, .push, .full, .cmd_in(cin), .cmd_valid(cv),
    .cmd_take(ct), .cmd_out(cq));
  rmdr_back u_back (.clk, .rst, .cmd_valid(cv), .cmd_take(ct), .cmd(cq),
    .start_sum, .start_dev, .start_rel, .start_cnt, .empty, .pop, .res(r));

  assign mean = r.mean;
  assign mean_deviation = r.mean_deviation;
  assign reliability = r.reliability;
  assign samples_seen = r.samples_seen;
endmodule

>>> tb/testbench.sv
// Testbench for running_mean_deviation_reliability_top: directed table, then random phases.
// Checks each item against an in-bench predictor or its typed row. Uses rmdr_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import rmdr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic action = ACT_ADD;
  logic signed [31:0] sample = '0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_START_SUM;
  logic [63:0] cfg_data = '0;
  logic full, empty;
  logic signed [31:0] mean;
  logic [31:0] mean_deviation;
  logic [22:0] reliability;
  logic [31:0] samples_seen;

  running_mean_deviation_reliability_top u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action), .sample(sample),
    .empty(empty), .pop(pop), .mean(mean), .mean_deviation(mean_deviation),
    .reliability(reliability), .samples_seen(samples_seen),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  localparam logic [63:0] REL_SUM_MAX = (64'd1 << RSUM_W) - 1;
  localparam logic [63:0] REL_OUT_MAX = (64'd1 << REL_W) - 1;
  localparam logic [63:0] U32_MAX = 64'hFFFF_FFFF;

  // predictor state
  logic signed [63:0] st_sum_cfg;
  logic [63:0] st_dev_cfg, st_rel_cfg, st_cnt_cfg;
  logic signed [63:0] run_sum;
  logic [63:0] dev_sum, rel_sum, sample_total;
  logic signed [31:0] mean_v;
  logic [31:0] dev_v;
  logic [22:0] rel_v;

  res_t stats_q[$];
  int errors = 0;
  bit idle_on = 1'b1;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) return t[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return t[63:0];
  endfunction

  function automatic logic [63:0] abs_diff64(logic signed [63:0] a, logic signed [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [63:0] umin64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic res_t predict_stats(logic act, logic signed [31:0] smp);
    logic signed [63:0] s, cnt, prev_mean, new_mean;
    logic [64:0] t;
    logic [63:0] shift, part, rs, qv;
    res_t r;
    s = smp;
    if (act == ACT_RESTART) begin
      run_sum = st_sum_cfg;
      dev_sum = st_dev_cfg;
      rel_sum = st_rel_cfg;
      sample_total = st_cnt_cfg;
      mean_v = '0;
      dev_v = '0;
      rel_v = '0;
    end else begin
      if (sample_total != 0) begin
        cnt = sample_total;
        prev_mean = run_sum / cnt;
        new_mean = sat_add64(run_sum, s) / (cnt + 64'sd1);
        if (new_mean > 64'sd2147483647) mean_v = 32'sh7FFF_FFFF;
        else if (new_mean < -64'sd2147483648) mean_v = 32'sh8000_0000;
        else mean_v = new_mean[31:0];
        t = {1'b0, dev_sum} + {1'b0, abs_diff64(new_mean, s)};
        dev_sum = t[64] ? '1 : t[63:0];
        qv = umin64(dev_sum / sample_total, U32_MAX);
        dev_v = qv[31:0];
        shift = umin64(abs_diff64(prev_mean, new_mean), U32_MAX);
        if (dev_v == 0) begin
          rs = rel_sum + HUNDRED_FX;
          rel_sum = (rs > REL_SUM_MAX) ? REL_SUM_MAX : rs;
        end else if (shift < {32'd0, dev_v}) begin
          part = HUNDRED_FX - (shift * HUNDRED_FX) / {32'd0, dev_v};
          rs = rel_sum + part;
          rel_sum = (rs > REL_SUM_MAX) ? REL_SUM_MAX : rs;
        end
        qv = umin64(rel_sum / sample_total, REL_OUT_MAX);
        rel_v = qv[22:0];
      end
      run_sum = sat_add64(run_sum, s);
      if (sample_total < U32_MAX) sample_total = sample_total + 1;
    end
    r.mean = mean_v;
    r.mean_deviation = dev_v;
    r.reliability = rel_v;
    r.samples_seen = sample_total[31:0];
    return r;
  endfunction

  // push is left high between back-to-back items; lowered on an idle gap and by drain_items
  task automatic send_item(logic act, logic [31:0] smp, bit typed, res_t typed_res);
    res_t r;
    if (idle_on && $urandom_range(99) < 35) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    sample <= smp;
    @(posedge clk);
    while (full) @(posedge clk);
    r = predict_stats(act, smp);
    stats_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_items();
    push <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_starts(logic [63:0] s, logic [63:0] d, logic [63:0] rl, logic [63:0] c);
    logic [63:0] vals[4];
    vals = '{s, d, rl, c};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    st_sum_cfg = s;
    st_dev_cfg = d & 64'h7FFF_FFFF_FFFF_FFFF;
    st_rel_cfg = rl & REL_SUM_MAX;
    st_cnt_cfg = c & U32_MAX;
  endtask

  // result side: pop idles at random while idle_on is set, checks each accepted item
  always @(posedge clk) begin
    res_t e;
    if (!rst && pop && !empty) begin
      if (stats_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = stats_q.pop_front();
        if (mean !== e.mean) begin
          $error("mean exp %0d got %0d", e.mean, mean); errors++;
        end
        if (mean_deviation !== e.mean_deviation) begin
          $error("mean_deviation exp %0d got %0d", e.mean_deviation, mean_deviation); errors++;
        end
        if (reliability !== e.reliability) begin
          $error("reliability exp %0d got %0d", e.reliability, reliability); errors++;
        end
        if (samples_seen !== e.samples_seen) begin
          $error("samples_seen exp %0d got %0d", e.samples_seen, samples_seen); errors++;
        end
      end
    end
    pop <= !idle_on || ($urandom_range(99) >= 35);
  end

  typedef struct {
    logic act;
    logic [31:0] smp;
    bit typed;
    res_t res;
  } dir_row_t;

  initial begin
    dir_row_t dir_tab[];
    logic signed [31:0] base;
    logic [31:0] smp;
    logic [63:0] cs, cd, cr, cc;
    int mode;
    st_sum_cfg = '0; st_dev_cfg = '0; st_rel_cfg = '0; st_cnt_cfg = '0;
    run_sum = '0; dev_sum = '0; rel_sum = '0; sample_total = '0;
    mean_v = '0; dev_v = '0; rel_v = '0;
    dir_tab = '{
      '{ACT_RESTART, 32'h0,         1, '{mean: 0, mean_deviation: 0, reliability: 0, samples_seen: 0}},
      '{ACT_ADD,     32'h0000_0000, 1, '{mean: 0, mean_deviation: 0, reliability: 0, samples_seen: 1}},
      '{ACT_ADD,     32'h7FFF_FFFF, 0, '0},
      '{ACT_ADD,     32'h8000_0000, 0, '0},
      '{ACT_ADD,     32'h0001_0000, 0, '0},
      '{ACT_ADD,     32'hFFFF_0000, 0, '0},
      '{ACT_ADD,     32'hFFFF_FFFF, 0, '0},
      '{ACT_RESTART, 32'hFFFF_FFFF, 1, '{mean: 0, mean_deviation: 0, reliability: 0, samples_seen: 0}},
      '{ACT_ADD,     32'h8000_0000, 1, '{mean: 0, mean_deviation: 0, reliability: 0, samples_seen: 1}},
      '{ACT_ADD,     32'h8000_0000, 0, '0},
      '{ACT_ADD,     32'h8000_0000, 0, '0},
      '{ACT_RESTART, 32'h0,         1, '{mean: 0, mean_deviation: 0, reliability: 0, samples_seen: 0}},
      '{ACT_ADD,     32'h0005_0000, 0, '0},
      '{ACT_ADD,     32'h0005_0000, 0, '0},
      '{ACT_ADD,     32'h0005_0000, 0, '0},
      '{ACT_ADD,     32'h0005_8000, 0, '0},
      '{ACT_ADD,     32'h0004_8000, 0, '0},
      '{ACT_ADD,     32'h0005_0100, 0, '0},
      '{ACT_ADD,     32'h7FFF_FFFF, 0, '0},
      '{ACT_ADD,     32'h0000_0001, 0, '0}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send_item(dir_tab[i].act, dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].res);
    drain_items();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin cs = 64'h7FFF_FFFF_FFFF_FFFF; cd = 0; cr = 0; cc = 1; end
        1: begin cs = 64'h8000_0000_0000_0000; cd = 0; cr = 0; cc = 1; end
        2: begin cs = 64'h7FFF_FFFF_FFFF_FFFF; cd = 64'h7FFF_FFFF_FFFF_FFFF;
                 cr = REL_SUM_MAX; cc = U32_MAX; end
        3: begin cs = 64'h8000_0000_0000_0000; cd = '1; cr = '1; cc = 64'hFFFF_FFFF_FFFF_FFFF; end
        4: begin cs = 0; cd = 0; cr = 0; cc = 0; end
        default: begin
          cc = $urandom_range(0, 20);
          cs = {{32{1'b0}}, $urandom} - {{32{1'b0}}, $urandom};
          cd = {$urandom, $urandom};
          cr = {$urandom, $urandom};
          if ($urandom_range(1)) begin cd = $urandom_range(0, 1 << 20); cr = $urandom_range(0, 1 << 24); end
        end
      endcase
      write_starts(cs, cd, cr, cc);
      idle_on = (ph != 4);
      base = $urandom;
      if ($urandom_range(1)) base = $signed(base) >>> $urandom_range(0, 16);
      send_item(ACT_RESTART, $urandom, 0, '0);
      for (int n = 0; n < 80; n++) begin
        mode = $urandom_range(99);
        if (mode < 5) send_item(ACT_RESTART, $urandom, 0, '0);
        else begin
          if (mode < 30) smp = $urandom;
          else if (mode < 75) smp = base + $urandom_range(0, 255) - 128;
          else if (mode < 85) smp = base;
          else smp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          send_item(ACT_ADD, smp, 0, '0);
        end
      end
      drain_items();
    end
    idle_on = 1'b1;

    if (errors == 0) begin
      $display("running_mean_deviation_reliability_top regression: pass");
    end else begin
      $display("running_mean_deviation_reliability_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("running_mean_deviation_reliability_top regression: fail");
    $finish;
  end
endmodule
